FILE: src/lrs_pkg.sv
package lrs_pkg;

  localparam int ACC_W = 66;
  localparam int MC_W  = 48;
  localparam int MPL_W = 18;
  localparam int Q_W   = 46;
  localparam int T_W   = 17;
  localparam int T_ONE = 65536;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_PROD = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL1 = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

FILE: src/layer_radiance_sweep.sv
// layer_radiance_sweep: one layer of a radiative transfer sweep per input transfer.
// Input channel in_valid_i/in_ready_o carries the layer fields; a transfer with
// start_req_i set first loads the running radiance from boundary_i and emits it
// as a result with is_boundary_o set. Every layer then emits one result with
// last_o set: running = T*running + source contribution, rounded and saturated.
// method_linear_i is written when method_linear_we_i is high; the user must write
// it only while idle, as the block itself does not enforce this. A sloped linear
// layer runs a serial multiply for mu*ds, a restoring division of one quotient
// bit per cycle, two more multiplies and a rounding step. A saturated slope skips
// the division loop. Constant mode or a zero-thickness layer skips mu*ds and the
// division. One shift-add multiplier is shared by all three multiplies.
// The next item is taken once the sequencer is idle and the output register is
// free or being read. A stalled receiver holds the result in the output
// register and the sequencer waits before writing the final result.
// Reset clears the running radiance to zero and selects the linear method.
module layer_radiance_sweep
  import lrs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               method_linear_we_i,
  input  logic               method_linear_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_req_i,
  input  logic signed [31:0] boundary_i,
  input  logic signed [31:0] source_out_i,
  input  logic signed [31:0] source_in_i,
  input  logic signed [31:0] tau_out_i,
  input  logic signed [31:0] tau_in_i,
  input  logic        [16:0] transmission_i,
  input  logic signed [17:0] signed_mu_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] radiance_o,
  output logic               is_boundary_o,
  output logic               zero_depth_error_o,
  output logic               last_o
);

  localparam int UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int NUM_W = 51 + UP;
  localparam int DEN_W = 33 + DN;

  state_e state_q, state_d;

  logic               lin_cfg_q;
  logic signed [31:0] run_q, run_d;
  logic signed [31:0] s_out_q, s_in_q;
  logic [T_W-1:0]     t_q, u_q, t_in;
  logic [MPL_W-1:0]   mu_mag_q;
  logic [32:0]        ds_mag_q, dt_mag_q;
  logic               qneg_q, lin_q, lin_ok_q;
  logic signed [Q_W:0] q_q;
  logic signed [ACC_W-1:0] fin_q;
  logic signed [32:0] ds, dt;
  logic               accept, slot_free;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] rad_q, rad_d;
  logic               isb_q, isb_d, err_q, err_d, last_q, last_d;

  logic                    mul_start, mul_done, div_start, div_done;
  logic signed [MC_W-1:0]  mul_mc;
  logic [MPL_W-1:0]        mul_mp;
  logic signed [ACC_W-1:0] mul_init, mul_acc;
  logic [Q_W-1:0]          div_quot;

  logic [ACC_W-1:0] mag;
  logic [48:0]      rr;
  logic signed [31:0] rounded;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  assign ds   = 33'(source_in_i) - 33'(source_out_i);
  assign dt   = 33'(tau_in_i) - 33'(tau_out_i);
  assign t_in = (transmission_i > T_W'(T_ONE)) ? T_W'(T_ONE) : transmission_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_cfg_q <= 1'b1;
    end else if (method_linear_we_i) begin
      lin_cfg_q <= method_linear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_out_q  <= source_out_i;
      s_in_q   <= source_in_i;
      t_q      <= t_in;
      u_q      <= T_W'(T_ONE) - t_in;
      mu_mag_q <= signed_mu_i[17] ? MPL_W'(-signed_mu_i) : MPL_W'(signed_mu_i);
      ds_mag_q <= ds[32] ? 33'(-ds) : 33'(ds);
      dt_mag_q <= dt[32] ? 33'(-dt) : 33'(dt);
      qneg_q   <= signed_mu_i[17] ^ ds[32] ^ dt[32];
      lin_q    <= lin_cfg_q;
      lin_ok_q <= lin_cfg_q && (dt != 33'sd0);
    end
    if (div_done) begin
      q_q <= qneg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end
    if (mul_done && state_q == S_MUL2) begin
      fin_q <= mul_acc;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_mc    = '0;
    mul_mp    = '0;
    mul_init  = '0;
    div_start = 1'b0;
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOAD;
      end
      S_LOAD: begin
        mul_start = 1'b1;
        if (lin_ok_q) begin
          mul_mc  = MC_W'($signed({1'b0, ds_mag_q}));
          mul_mp  = mu_mag_q;
          state_d = S_PROD;
        end else begin
          mul_mc  = MC_W'($signed({run_q, 1'b0}));
          mul_mp  = MPL_W'(t_q);
          state_d = S_MUL1;
        end
      end
      S_PROD: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_mc    = MC_W'($signed({run_q, 1'b0})) - MC_W'(s_in_q);
          mul_mp    = MPL_W'(t_q);
          mul_init  = ACC_W'($signed({s_out_q, 16'd0}));
          state_d   = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_mc    = lin_q ? (lin_ok_q ? MC_W'(q_q) : '0) : MC_W'(s_out_q);
          mul_mp    = MPL_W'(u_q);
          mul_init  = mul_acc;
          state_d   = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  lrs_mul_serial u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mc),
    .mplier_i(mul_mp),
    .acc_i   (mul_init),
    .done_o  (mul_done),
    .acc_o   (mul_acc)
  );

  lrs_div_serial #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (NUM_W'(mul_acc[50:0]) << UP),
    .den_i  (DEN_W'(dt_mag_q) << DN),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // round half away from zero, then saturate
  always_comb begin
    mag = fin_q[ACC_W-1] ? ACC_W'(-fin_q) : ACC_W'(fin_q);
    rr  = 49'((mag + ACC_W'(65536)) >> 17);
    if (fin_q[ACC_W-1]) begin
      rounded = (rr > 49'd2147483648) ? 32'sh80000000 : -$signed(rr[31:0]);
    end else begin
      rounded = (rr > 49'd2147483647) ? 32'sh7fffffff : $signed(rr[31:0]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rad_d       = rad_q;
    isb_d       = isb_q;
    err_d       = err_q;
    last_d      = last_q;
    run_d       = run_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (accept && start_req_i) begin
      run_d       = boundary_i;
      out_valid_d = 1'b1;
      rad_d       = boundary_i;
      isb_d       = 1'b1;
      err_d       = 1'b0;
      last_d      = 1'b0;
    end else if (state_q == S_OUT && slot_free) begin
      run_d       = rounded;
      out_valid_d = 1'b1;
      rad_d       = rounded;
      isb_d       = 1'b0;
      err_d       = lin_q && !lin_ok_q;
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    isb_q  <= isb_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign radiance_o         = rad_q;
  assign is_boundary_o      = isb_q;
  assign zero_depth_error_o = err_q;
  assign last_o             = last_q;

endmodule

FILE: src/lrs_mul_serial.sv
module lrs_mul_serial
  import lrs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MC_W-1:0]  mcand_i,
  input  logic        [MPL_W-1:0] mplier_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int CNT_W = $clog2(MPL_W + 1);

  logic signed [ACC_W-1:0] acc_q, acc_d, mc_q, mc_d;
  logic        [MPL_W-1:0] mp_q, mp_d;
  logic        [CNT_W-1:0] cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = acc_i;
      mc_d   = ACC_W'(mcand_i);
      mp_d   = mplier_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d  = mc_q <<< 1;
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MPL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

FILE: src/lrs_div_serial.sv
module lrs_div_serial
  import lrs_pkg::*;
#(
  parameter int NUM_W = 51,
  parameter int DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W:0]   p_q, p_d, pn;
  logic [DEN_W-1:0] den_q, den_d;
  logic [Q_W-1:0]   lo_q, lo_d, quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [NUM_W-Q_W-1:0] hi;

  assign hi = num_i[NUM_W-1:Q_W];
  assign pn = {p_q[DEN_W-1:0], lo_q[Q_W-1]};

  always_comb begin
    p_d    = p_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d = den_i;
      lo_d  = num_i[Q_W-1:0];
      cnt_d = '0;
      if ((DEN_W + 1)'(hi) >= (DEN_W + 1)'(den_i)) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        p_d    = (DEN_W + 1)'(hi);
        quot_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      lo_d = lo_q << 1;
      if (pn >= {1'b0, den_q}) begin
        p_d    = pn - {1'b0, den_q};
        quot_d = {quot_q[Q_W-2:0], 1'b1};
      end else begin
        p_d    = pn;
        quot_d = {quot_q[Q_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
